// File: hdl/qemp_pkg.sv
// ----------------------------------------------------------------------------
// qemp_pkg - shared types and constants
// Register indexes, profile codes and sequencer states of the motion profile.
// ----------------------------------------------------------------------------
`default_nettype none

package qemp_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned PosW     = 32;
  localparam int unsigned MsW      = 16;
  localparam int unsigned RateW    = 63;   // coefficient magnitude, Q31.32
  localparam int unsigned DvdW     = 64;
  localparam int unsigned KW       = 32;

  localparam logic [CfgAddrW-1:0] REG_TARGET_X  = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_TARGET_Y  = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_MOVE_X_EN = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_MOVE_Y_EN = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_DURATION  = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_PROFILE_X = 3'd5;
  localparam logic [CfgAddrW-1:0] REG_PROFILE_Y = 3'd6;

  typedef enum logic [1:0] {
    PROF_LINEAR = 2'd0,
    PROF_ACCEL  = 2'd1,
    PROF_EASE   = 2'd2,
    PROF_DECEL  = 2'd3
  } profile_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DPREP = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_MPREP = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// File: hdl/quadratic_ease_motion_profile.sv
// ----------------------------------------------------------------------------
// quadratic_ease_motion_profile - two-axis ease in / ease out position generator
// Start items set up per-axis coefficients with a bit-serial divider; tick
// items evaluate the curve with a bit-serial shift-add multiplier.
// ----------------------------------------------------------------------------
//  channel  | dir | ports                         | contents
//  ---------+-----+-------------------------------+------------------------------
//  in_      | in  | tvalid tready tdata tuser     | tuser start_req, tdata elapsed_ms
//  out_     | out | tvalid tready tdata           | position_x, position_y, moving
//  cfg_     | in  | we addr wdata                 | register write, no read-back
//
//  Start item: two 64-step restoring divisions in one divider, one per axis.
//  Tick item: two shift-add multiplies while moving; none when idle, at the
//  finish time or for a zero-duration start.
//  One item at a time; in_tready is high only in the idle state. The result
//  waits in the output register and the next item is taken meanwhile.
//  Reset (rst_n low, synchronous) clears config, motion state, out_tvalid; goes idle.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_ease_motion_profile
  import qemp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [15:0]         in_tdata,   // [15:0] elapsed_ms
  input  wire logic [0:0]          in_tuser,   // [0] start_req
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [71:0]              out_tdata,  // [31:0] position_x, [63:32] position_y,
                                               // [64] moving, [71:65] zero
  input  wire logic                cfg_we,
  input  wire logic [CfgAddrW-1:0] cfg_addr,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  // configuration
  logic [PosW-1:0] target_r [2];
  logic [1:0]      move_en_r;
  logic [MsW-1:0]  duration_r;
  logic [1:0]      profile_r [2];

  // motion state
  logic [PosW-1:0]  pos_r    [2];
  logic [PosW-1:0]  origin_r [2];
  logic [PosW-1:0]  goal_r   [2];
  logic [RateW-1:0] rmag_r   [2];
  logic [1:0]       rneg_r;
  logic [MsW-1:0]   switch_r [2];
  logic [1:0]       mode_r   [2];
  logic [MsW-1:0]   finish_r;
  logic [MsW-1:0]   clock_r;
  logic             active_r;

  // sequencer and shared units
  state_t          state_r;
  logic            axis_r;
  logic [5:0]      cnt_r;
  logic [31:0]     div_r;
  logic [31:0]     rem_r;
  logic [DvdW-1:0] dvd_r;
  logic [DvdW-1:0] quo_r;
  logic            dneg_r;
  logic [KW-1:0]   k_r;
  logic [94:0]     acc_r;
  logic            minus_r;
  logic [PosW-1:0] base_r;
  logic [71:0]     out_data_r;
  logic            out_valid_r;

  logic            accept;
  logic [16:0]     csum;
  logic [MsW-1:0]  cnew;
  logic [MsW-1:0]  mul_a, mul_b;
  logic [31:0]     mul_p;
  logic [MsW:0]    half_p1;
  logic [32:0]     diff;
  logic [31:0]     dmag;
  logic [32:0]     trial;
  logic            ge;
  logic [MsW-1:0]  tleft;
  logic [94:0]     acc_nxt;
  logic [31:0]     off;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign csum = {1'b0, clock_r} + {1'b0, in_tdata};
  assign cnew = csum[16] ? {MsW{1'b1}} : csum[MsW-1:0];

  assign half_p1 = ({1'b0, finish_r} + 17'd1) >> 1;
  assign tleft   = finish_r - clock_r;

  // shared 16x16 multiplier: divisor at set-up, time term at a tick
  always_comb begin
    mul_a = finish_r;
    mul_b = finish_r;
    if (state_r == ST_DPREP) begin
      if (profile_t'(mode_r[axis_r]) == PROF_EASE) begin
        mul_a = half_p1[MsW-1:0];
        mul_b = half_p1[MsW-1:0];
      end
    end else begin
      if (clock_r < switch_r[axis_r]) begin
        mul_a = clock_r;
        mul_b = clock_r;
      end else begin
        mul_a = tleft;
        mul_b = tleft;
      end
    end
  end
  assign mul_p = mul_a * mul_b;

  assign diff = {goal_r[axis_r][PosW-1], goal_r[axis_r]}
              - {origin_r[axis_r][PosW-1], origin_r[axis_r]};
  assign dmag = diff[32] ? 32'(-diff) : diff[31:0];

  assign trial = {rem_r, dvd_r[DvdW-1]};
  assign ge    = trial >= {1'b0, div_r};

  assign acc_nxt = {acc_r[93:0], 1'b0} + (k_r[KW-1] ? {32'd0, rmag_r[axis_r]} : 95'd0);
  assign off     = acc_r[63:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r[0] <= '0; target_r[1] <= '0;
      move_en_r <= '0; duration_r <= '0;
      profile_r[0] <= '0; profile_r[1] <= '0;
      pos_r[0] <= '0; pos_r[1] <= '0;
      origin_r[0] <= '0; origin_r[1] <= '0;
      goal_r[0] <= '0; goal_r[1] <= '0;
      rmag_r[0] <= '0; rmag_r[1] <= '0; rneg_r <= '0;
      switch_r[0] <= '0; switch_r[1] <= '0;
      mode_r[0] <= '0; mode_r[1] <= '0;
      finish_r <= '0; clock_r <= '0; active_r <= 1'b0;
      state_r <= ST_IDLE; axis_r <= 1'b0; cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_TARGET_X:  target_r[0] <= cfg_wdata;
          REG_TARGET_Y:  target_r[1] <= cfg_wdata;
          REG_MOVE_X_EN: move_en_r[0] <= cfg_wdata[0];
          REG_MOVE_Y_EN: move_en_r[1] <= cfg_wdata[0];
          REG_DURATION:  duration_r <= cfg_wdata[MsW-1:0];
          REG_PROFILE_X: profile_r[0] <= cfg_wdata[1:0];
          REG_PROFILE_Y: profile_r[1] <= cfg_wdata[1:0];
          default: ;
        endcase
      end

      if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            axis_r <= 1'b0;
            if (in_tuser[0]) begin
              if (duration_r == '0) begin
                if (move_en_r[0]) pos_r[0] <= target_r[0];
                if (move_en_r[1]) pos_r[1] <= target_r[1];
                active_r <= 1'b0;
                state_r  <= ST_DONE;
              end else begin
                origin_r[0] <= pos_r[0];
                origin_r[1] <= pos_r[1];
                goal_r[0] <= move_en_r[0] ? target_r[0] : pos_r[0];
                goal_r[1] <= move_en_r[1] ? target_r[1] : pos_r[1];
                finish_r <= duration_r;
                clock_r  <= '0;
                mode_r[0] <= profile_r[0];
                mode_r[1] <= profile_r[1];
                active_r <= 1'b1;
                state_r  <= ST_DPREP;
              end
            end else if (active_r) begin
              clock_r <= cnew;
              if (cnew >= finish_r) begin
                pos_r[0] <= goal_r[0];
                pos_r[1] <= goal_r[1];
                active_r <= 1'b0;
                state_r  <= ST_DONE;
              end else begin
                state_r <= ST_MPREP;
              end
            end else begin
              state_r <= ST_DONE;
            end
          end
        end

        ST_DPREP: begin
          unique case (profile_t'(mode_r[axis_r]))
            PROF_LINEAR: begin
              div_r <= {16'd0, finish_r};
              switch_r[axis_r] <= finish_r;
            end
            PROF_ACCEL: begin
              div_r <= mul_p;
              switch_r[axis_r] <= finish_r;
            end
            PROF_EASE: begin
              div_r <= {mul_p[30:0], 1'b0};
              switch_r[axis_r] <= half_p1[MsW-1:0];
            end
            default: begin
              div_r <= mul_p;
              switch_r[axis_r] <= '0;
            end
          endcase
          dneg_r  <= diff[32];
          dvd_r   <= {dmag, 32'd0};
          rem_r   <= '0;
          quo_r   <= '0;
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end

        ST_DIV: begin
          // one quotient bit a cycle, restoring
          rem_r <= ge ? 32'(trial - {1'b0, div_r}) : trial[31:0];
          quo_r <= {quo_r[DvdW-2:0], ge};
          dvd_r <= {dvd_r[DvdW-2:0], 1'b0};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            rmag_r[axis_r] <= quo_r[DvdW-2] ? {RateW{1'b1}} : {quo_r[DvdW-3:0], ge};
            rneg_r[axis_r] <= dneg_r;
            if (axis_r) begin
              state_r <= ST_DONE;
            end else begin
              axis_r  <= 1'b1;
              state_r <= ST_DPREP;
            end
          end
        end

        ST_MPREP: begin
          if (profile_t'(mode_r[axis_r]) == PROF_LINEAR) begin
            k_r     <= {16'd0, clock_r};
            base_r  <= origin_r[axis_r];
            minus_r <= rneg_r[axis_r];
          end else if (clock_r < switch_r[axis_r]) begin
            k_r     <= mul_p;
            base_r  <= origin_r[axis_r];
            minus_r <= rneg_r[axis_r];
          end else begin
            k_r     <= mul_p;
            base_r  <= goal_r[axis_r];
            minus_r <= !rneg_r[axis_r];
          end
          acc_r   <= '0;
          cnt_r   <= '0;
          state_r <= ST_MUL;
        end

        ST_MUL: begin
          // shift-add, most significant multiplier bit first
          k_r   <= {k_r[KW-2:0], 1'b0};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd32) begin
            pos_r[axis_r] <= minus_r ? base_r - off : base_r + off;
            if (axis_r) begin
              state_r <= ST_DONE;
            end else begin
              axis_r  <= 1'b1;
              state_r <= ST_MPREP;
            end
          end else begin
            acc_r <= acc_nxt;
          end
        end

        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            state_r <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= {7'd0, active_r, pos_r[1], pos_r[0]};
    end
  end

endmodule

`default_nettype wire
